[rtl/lgsf_pkg.sv]
// Shared types, constants and lookup functions for the LED grid SysEx framer.
`default_nettype none

package lgsf_pkg;

   localparam int MAX_CHUNK_BYTES_DEFAULT = 250;

   localparam logic [7:0] EOX_BYTE      = 8'hF7;
   localparam logic [7:0] SOX_BYTE      = 8'hF0;
   localparam logic [7:0] HEADER_BYTES  = 8'd7;
   localparam logic [7:0] COLOUR_NEWER  = 8'h03;
   localparam logic [7:0] COLOUR_OLDER  = 8'h0B;
   localparam logic [7:0] PAD_PREFIX    = 8'h03;
   localparam logic [2:0] PER_PAD_NEWER = 3'd5;
   localparam logic [2:0] PER_PAD_OLDER = 3'd4;

   // Input commands
   localparam logic [1:0] CMD_PAD   = 2'd0;
   localparam logic [1:0] CMD_EOF   = 2'd1;
   localparam logic [1:0] CMD_PROG  = 2'd2;
   localparam logic [1:0] CMD_LIVE  = 2'd3;

   // Controller models
   localparam logic [2:0] MODEL_PRO_MK3  = 3'd0;
   localparam logic [2:0] MODEL_X        = 3'd1;
   localparam logic [2:0] MODEL_MINI_MK3 = 3'd2;
   localparam logic [2:0] MODEL_MK2      = 3'd3;
   localparam logic [2:0] MODEL_PRO      = 3'd4;

   // One item's work, as handed to the byte sequencer
   typedef struct packed {
      logic       eox;        // close the open chunk first
      logic       hdr;        // emit the six-byte model header
      logic       pad;        // colour chunk / pad bytes follow
      logic       nf;         // newer format
      logic       prog;       // programmer mode (else live)
      logic [2:0] model;
      logic [6:0] pad_num;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } job_type;

   function automatic logic tens(input logic [6:0] p);
      return (p == 7'd10) || (p == 7'd20) || (p == 7'd30) || (p == 7'd40) ||
             (p == 7'd50) || (p == 7'd60) || (p == 7'd70) || (p == 7'd80) ||
             (p == 7'd90) || (p == 7'd100) || (p == 7'd110) || (p == 7'd120);
   endfunction

   function automatic logic pad_valid(input logic [2:0] model, input logic [6:0] p);
      logic ok;
      ok = 1'b0;
      case (model)
         MODEL_PRO_MK3: begin
            ok = (p >= 7'd1) && (p <= 7'd108) && (p != 7'd9) && (p != 7'd100);
         end
         MODEL_X, MODEL_MINI_MK3: begin
            ok = (p >= 7'd11) && (p <= 7'd99) && !tens(p);
         end
         MODEL_MK2: begin
            ok = ((p >= 7'd11) && (p <= 7'd89) && !tens(p)) ||
                 ((p >= 7'd104) && (p <= 7'd111));
         end
         MODEL_PRO: begin
            ok = (p >= 7'd1) && (p <= 7'd98) && (p != 7'd9) && (p != 7'd90);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   function automatic logic [7:0] device_id(input logic [2:0] model);
      logic [7:0] v;
      case (model)
         MODEL_PRO_MK3:  v = 8'h0E;
         MODEL_X:        v = 8'h0C;
         MODEL_MINI_MK3: v = 8'h0D;
         MODEL_MK2:      v = 8'h18;
         MODEL_PRO:      v = 8'h10;
         default:        v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] mode_cmd(input logic [2:0] model);
      logic [7:0] v;
      case (model)
         MODEL_PRO_MK3, MODEL_X, MODEL_MINI_MK3: v = 8'h0E;
         MODEL_MK2:                              v = 8'h22;
         MODEL_PRO:                              v = 8'h2C;
         default:                                v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] prog_val(input logic [2:0] model);
      logic [7:0] v;
      case (model)
         MODEL_PRO: v = 8'h03;
         default:   v = 8'h01;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/lgsf_emit.sv]
// Byte sequencer: holds one item's job and streams its SysEx bytes through an output register.
`default_nettype none

module lgsf_emit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire lgsf_pkg::job_type job,
   output logic                  job_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_message_end,
   output logic                  rsp_run_last
);

   typedef enum logic [4:0] {
      PH_DONE, PH_EOX_A, PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5,
      PH_COLOUR, PH_PFX, PH_PIDX, PH_RED, PH_GREEN, PH_BLUE,
      PH_MODE_CMD, PH_MODE_VAL, PH_EOX_END
   } phase_type;

   phase_type          phase_ff, phase_in, next_phase, start_phase;
   lgsf_pkg::job_type  job_ff, job_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         byte_ff, byte_in, cur_byte;
   logic               end_ff, end_in, cur_end;
   logic               last_ff, last_in;
   logic               active, advance, last, load;

   always_comb begin
      cur_byte   = 8'h00;
      cur_end    = 1'b0;
      next_phase = PH_DONE;
      case (phase_ff)
         PH_EOX_A: begin
            cur_byte   = lgsf_pkg::EOX_BYTE;
            cur_end    = 1'b1;
            next_phase = job_ff.hdr ? PH_HDR0 : PH_DONE;
         end
         PH_HDR0: begin
            cur_byte   = lgsf_pkg::SOX_BYTE;
            next_phase = PH_HDR1;
         end
         PH_HDR1: begin
            cur_byte   = 8'h00;
            next_phase = PH_HDR2;
         end
         PH_HDR2: begin
            cur_byte   = 8'h20;
            next_phase = PH_HDR3;
         end
         PH_HDR3: begin
            cur_byte   = 8'h29;
            next_phase = PH_HDR4;
         end
         PH_HDR4: begin
            cur_byte   = 8'h02;
            next_phase = PH_HDR5;
         end
         PH_HDR5: begin
            cur_byte   = lgsf_pkg::device_id(job_ff.model);
            next_phase = job_ff.pad ? PH_COLOUR : PH_MODE_CMD;
         end
         PH_COLOUR: begin
            cur_byte   = job_ff.nf ? lgsf_pkg::COLOUR_NEWER : lgsf_pkg::COLOUR_OLDER;
            next_phase = job_ff.nf ? PH_PFX : PH_PIDX;
         end
         PH_PFX: begin
            cur_byte   = lgsf_pkg::PAD_PREFIX;
            next_phase = PH_PIDX;
         end
         PH_PIDX: begin
            cur_byte   = {1'b0, job_ff.pad_num};
            next_phase = PH_RED;
         end
         PH_RED: begin
            cur_byte   = job_ff.red;
            next_phase = PH_GREEN;
         end
         PH_GREEN: begin
            cur_byte   = job_ff.green;
            next_phase = PH_BLUE;
         end
         PH_BLUE: begin
            cur_byte   = job_ff.blue;
            next_phase = PH_DONE;
         end
         PH_MODE_CMD: begin
            cur_byte   = lgsf_pkg::mode_cmd(job_ff.model);
            next_phase = PH_MODE_VAL;
         end
         PH_MODE_VAL: begin
            cur_byte   = job_ff.prog ? lgsf_pkg::prog_val(job_ff.model) : 8'h00;
            next_phase = PH_EOX_END;
         end
         PH_EOX_END: begin
            cur_byte   = lgsf_pkg::EOX_BYTE;
            cur_end    = 1'b1;
            next_phase = PH_DONE;
         end
         default: begin
            cur_byte   = 8'h00;
            next_phase = PH_DONE;
         end
      endcase
   end

   // Where a freshly loaded job starts
   always_comb begin
      if (job.eox) begin
         start_phase = PH_EOX_A;
      end else if (job.hdr) begin
         start_phase = PH_HDR0;
      end else if (job.pad) begin
         start_phase = job.nf ? PH_PFX : PH_PIDX;
      end else begin
         start_phase = PH_DONE;
      end
   end

   assign active    = (phase_ff != PH_DONE);
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign last      = (next_phase == PH_DONE);
   // Take the next job while the current one's last byte moves out
   assign job_ready = !active || (advance && last);
   assign load      = job_valid && job_ready;

   always_comb begin
      phase_in     = phase_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = active;
         byte_in      = cur_byte;
         end_in       = cur_end;
         last_in      = last;
         if (active) begin
            phase_in = next_phase;
         end
      end
      if (load) begin
         phase_in = start_phase;
         job_in   = job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff  <= job_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_message_end = end_ff;
   assign rsp_run_last    = last_ff;

endmodule

`default_nettype wire

[rtl/led_grid_sysex_framer_core.sv]
// Top level of the LED grid SysEx framer: chunk bookkeeping, pad decode and byte sequencer.
// The accepted job is registered, then its first byte is registered in the output register.
// Throughput: one byte per cycle while rsp_stall is low; an item emits 1 to 13 bytes (a typical
// pad 4 or 5), and some items emit none.
// The next item is taken in the cycle the previous item's last byte enters the output register.
// Reset (synchronous): no chunk open, chunk length 0, model 0, output empty.
`default_nettype none

module led_grid_sysex_framer_core #(
   parameter int MAX_CHUNK_BYTES = lgsf_pkg::MAX_CHUNK_BYTES_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_write_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [6:0] req_pad_num,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_message_end,
   output logic            rsp_run_last
);

   logic [2:0]        model_ff, model_in;
   logic              open_ff, open_in;
   logic [7:0]        len_ff, len_in;
   lgsf_pkg::job_type job;
   logic              job_ready, accept;
   logic              known, nf, valid_pad;
   logic [2:0]        per_pad;
   logic [8:0]        sum;
   logic              overflow;
   logic [7:0]        base;

   assign known     = (model_ff <= lgsf_pkg::MODEL_PRO);
   assign nf        = (model_ff <= lgsf_pkg::MODEL_MINI_MK3);
   assign valid_pad = lgsf_pkg::pad_valid(model_ff, req_pad_num);
   assign per_pad   = nf ? lgsf_pkg::PER_PAD_NEWER : lgsf_pkg::PER_PAD_OLDER;
   assign sum       = {1'b0, len_ff} + {6'd0, per_pad};
   assign overflow  = open_ff && (sum > 9'(MAX_CHUNK_BYTES));
   assign base      = (!open_ff || overflow) ? lgsf_pkg::HEADER_BYTES : len_ff;

   always_comb begin
      job.eox       = 1'b0;
      job.hdr       = 1'b0;
      job.pad       = 1'b0;
      job.nf        = nf;
      job.prog      = (req_cmd == lgsf_pkg::CMD_PROG);
      job.model     = model_ff;
      job.pad_num   = req_pad_num;
      job.red       = nf ? {1'b0, req_red[7:1]}   : {2'b00, req_red[7:2]};
      job.green     = nf ? {1'b0, req_green[7:1]} : {2'b00, req_green[7:2]};
      job.blue      = nf ? {1'b0, req_blue[7:1]}  : {2'b00, req_blue[7:2]};
      open_in       = open_ff;
      len_in        = len_ff;
      case (req_cmd)
         lgsf_pkg::CMD_PAD: begin
            if (valid_pad) begin
               job.eox = overflow;
               job.hdr = !open_ff || overflow;
               job.pad = 1'b1;
               open_in = 1'b1;
               len_in  = base + {5'd0, per_pad};
            end
         end
         lgsf_pkg::CMD_EOF: begin
            job.eox = open_ff;
            open_in = 1'b0;
            len_in  = 8'd0;
         end
         lgsf_pkg::CMD_PROG, lgsf_pkg::CMD_LIVE: begin
            // close any open chunk, then the mode message if the model is known
            job.eox = open_ff;
            job.hdr = known;
            open_in = 1'b0;
            len_in  = 8'd0;
         end
         default: begin
            job.eox = 1'b0;
         end
      endcase
      model_in = csr_write_enable ? csr_write_data : model_ff;
   end

   assign accept    = req_valid && job_ready;
   assign req_stall = !job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff <= lgsf_pkg::MODEL_PRO_MK3;
         open_ff  <= 1'b0;
         len_ff   <= 8'd0;
      end else begin
         model_ff <= model_in;
         if (accept) begin
            open_ff <= open_in;
            len_ff  <= len_in;
         end
      end
   end

   lgsf_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (req_valid),
      .job             (job),
      .job_ready       (job_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_message_end (rsp_message_end),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

`default_nettype wire

[rtl/lgsf_checker.sv]
// Port-level checker for the LED grid SysEx framer, bound to the top level.
`default_nettype none

module lgsf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_message_end,
   input wire logic       rsp_run_last
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_message_end) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // an EOX byte is flagged as message end and nothing else is
   a_eox_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_byte == 8'hF7) == rsp_message_end))
      else $error("message end flag does not match EOX byte");

   // output is empty the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind led_grid_sysex_framer_core lgsf_checker u_lgsf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_message_end (rsp_message_end),
   .rsp_run_last    (rsp_run_last)
);

`default_nettype wire
